// ----- rtl/lr_pkg.sv -----
`default_nettype none

package lr_pkg;

    localparam int CoordBits  = 16;
    localparam int FieldBits  = 16;
    localparam int ColorBits  = 16;
    localparam int ScrBits    = 12;
    localparam int DiffBits   = CoordBits + 1;
    localparam int ErrBits    = CoordBits + 2;
    localparam int CmpBits    = (CoordBits > ScrBits) ? CoordBits : ScrBits;
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = $clog2(QueueDepth);
    localparam int CfgIdxBits = 1;

    localparam logic [ScrBits-1:0] ScreenWidthReset  = ScrBits'(240);
    localparam logic [ScrBits-1:0] ScreenHeightReset = ScrBits'(320);

    typedef logic signed [CoordBits-1:0] t_coord;
    typedef logic signed [DiffBits-1:0]  t_diff;
    typedef logic        [DiffBits-1:0]  t_delta;
    typedef logic signed [ErrBits-1:0]   t_err;
    typedef logic signed [FieldBits-1:0] t_field;
    typedef logic        [ColorBits-1:0] t_color;
    typedef logic        [ScrBits-1:0]   t_scr;
    typedef logic        [CfgIdxBits-1:0] t_cfg_idx;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } t_mode;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    // one classified beat on its way to the walker
    typedef struct packed {
        t_mode  mode;
        t_coord major_pos;
        t_coord major_end;
        t_coord minor_pos;
        t_delta delta_major;
        t_delta delta_minor;
        logic   step_down;
        logic   swapped;
        t_color color;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/lr_setup.sv -----
`default_nettype none

module lr_setup (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_mode,
    input  wire logic [lr_pkg::FieldBits-1:0] i_x_start,
    input  wire logic [lr_pkg::FieldBits-1:0] i_y_start,
    input  wire logic [lr_pkg::FieldBits-1:0] i_x_end,
    input  wire logic [lr_pkg::FieldBits-1:0] i_y_end,
    input  wire logic [lr_pkg::ColorBits-1:0] i_pen_color,
    output logic                            o_push,
    output lr_pkg::t_cmd                    o_cmd,
    input  wire logic                       i_full
);
    import lr_pkg::*;

    logic   r_a_valid;
    t_mode  r_a_mode;
    t_coord r_a_xa, r_a_ya, r_a_xb, r_a_yb;
    t_diff  r_a_dx, r_a_dy;
    t_delta r_a_adx, r_a_ady;
    t_color r_a_color;

    t_coord xa, ya, xb, yb;
    t_diff  dx, dy;
    logic   accept;

    logic   steep, order, neg_major;
    t_coord maj_a, maj_b, min_a, min_b;
    t_diff  dmin;

    assign o_in_ready = !r_a_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_a_valid && !i_full;

    always_comb begin
        xa = t_coord'(i_x_start[CoordBits-1:0]);
        ya = t_coord'(i_y_start[CoordBits-1:0]);
        xb = t_coord'(i_x_end[CoordBits-1:0]);
        yb = t_coord'(i_y_end[CoordBits-1:0]);
        dx = t_diff'(xb) - t_diff'(xa);
        dy = t_diff'(yb) - t_diff'(ya);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_mode  <= t_mode'(i_mode);
            r_a_xa    <= xa;
            r_a_ya    <= ya;
            r_a_xb    <= xb;
            r_a_yb    <= yb;
            r_a_dx    <= dx;
            r_a_dy    <= dy;
            r_a_adx   <= dx[DiffBits-1] ? t_delta'(-dx) : t_delta'(dx);
            r_a_ady   <= dy[DiffBits-1] ? t_delta'(-dy) : t_delta'(dy);
            r_a_color <= i_pen_color;
        end
    end

    // steep lines walk along y; endpoints ordered so the major coordinate rises
    always_comb begin
        steep     = r_a_ady > r_a_adx;
        maj_a     = steep ? r_a_ya : r_a_xa;
        maj_b     = steep ? r_a_yb : r_a_xb;
        min_a     = steep ? r_a_xa : r_a_ya;
        min_b     = steep ? r_a_xb : r_a_yb;
        neg_major = steep ? r_a_dy[DiffBits-1] : r_a_dx[DiffBits-1];
        dmin      = steep ? r_a_dx : r_a_dy;
        order     = neg_major;

        o_cmd.mode        = r_a_mode;
        o_cmd.major_pos   = order ? maj_b : maj_a;
        o_cmd.major_end   = order ? maj_a : maj_b;
        o_cmd.minor_pos   = order ? min_b : min_a;
        o_cmd.delta_major = steep ? r_a_ady : r_a_adx;
        o_cmd.delta_minor = steep ? r_a_adx : r_a_ady;
        o_cmd.step_down   = order ? !dmin[DiffBits-1]
                                  : (dmin[DiffBits-1] || (dmin == '0));
        o_cmd.swapped     = steep;
        o_cmd.color       = r_a_color;
    end

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && i_full) |=> r_a_valid)
        else $error("setup stage dropped a beat while the queue was full");

endmodule

`default_nettype wire

// ----- rtl/lr_fifo.sv -----
`default_nettype none

module lr_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire lr_pkg::t_cmd i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output lr_pkg::t_cmd      o_data
);
    import lr_pkg::*;

    t_cmd                    r_mem [QueueDepth];
    logic [QueuePtrBits-1:0] r_wr_ptr, r_rd_ptr;
    logic [QueuePtrBits:0]   r_count;

    assign o_full  = r_count == (QueuePtrBits + 1)'(QueueDepth);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/lr_walker.sv -----
`default_nettype none

module lr_walker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire lr_pkg::t_cmd i_cmd,
    output logic              o_pop,
    input  wire lr_pkg::t_scr i_screen_width,
    input  wire lr_pkg::t_scr i_screen_height,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output lr_pkg::t_field    o_pixel_x,
    output lr_pkg::t_field    o_pixel_y,
    output lr_pkg::t_color    o_pixel_color,
    output logic              o_on_screen,
    output logic              o_last
);
    import lr_pkg::*;

    t_coord r_major_pos, r_major_end, r_minor_pos;
    t_err   r_err;
    t_delta r_dmajor, r_dminor;
    logic   r_step_down, r_swapped, r_active;
    t_color r_color;

    logic   r_out_valid;
    t_field r_px, r_py;
    t_color r_pcolor;
    logic   r_vis, r_last;

    logic   advance, is_load, emit;
    t_coord px, py;
    logic   vis, fin;
    t_err   err_sub;

    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = i_q_valid && advance;
    assign is_load = i_cmd.mode == MODE_LOAD;
    assign emit    = o_pop && !is_load && r_active;

    always_comb begin
        px  = r_swapped ? r_minor_pos : r_major_pos;
        py  = r_swapped ? r_major_pos : r_minor_pos;
        vis = !px[CoordBits-1] && (CmpBits'($unsigned(px)) < CmpBits'(i_screen_width))
           && !py[CoordBits-1] && (CmpBits'($unsigned(py)) < CmpBits'(i_screen_height));
        fin = r_major_pos >= r_major_end;
        err_sub = r_err - t_err'(r_dminor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos <= '0;
            r_major_end <= '0;
            r_minor_pos <= '0;
            r_err       <= '0;
            r_dmajor    <= '0;
            r_dminor    <= '0;
            r_step_down <= 1'b0;
            r_swapped   <= 1'b0;
            r_active    <= 1'b0;
            r_color     <= '0;
        end else if (o_pop && is_load) begin
            // a load replaces any line still in progress
            r_major_pos <= i_cmd.major_pos;
            r_major_end <= i_cmd.major_end;
            r_minor_pos <= i_cmd.minor_pos;
            r_err       <= t_err'(i_cmd.delta_major >> 1);
            r_dmajor    <= i_cmd.delta_major;
            r_dminor    <= i_cmd.delta_minor;
            r_step_down <= i_cmd.step_down;
            r_swapped   <= i_cmd.swapped;
            r_active    <= 1'b1;
            r_color     <= i_cmd.color;
        end else if (emit) begin
            if (err_sub[ErrBits-1]) begin
                r_minor_pos <= r_step_down ? r_minor_pos - t_coord'(1)
                                           : r_minor_pos + t_coord'(1);
                r_err       <= err_sub + t_err'(r_dmajor);
            end else begin
                r_err <= err_sub;
            end
            if (fin) begin
                r_active <= 1'b0;
            end else begin
                r_major_pos <= r_major_pos + t_coord'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_px     <= t_field'(px);
            r_py     <= t_field'(py);
            r_pcolor <= r_color;
            r_vis    <= vis;
            r_last   <= fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_on_screen   = r_vis;
    assign o_last        = r_last;

    a_load_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_load) |=> r_active)
        else $error("load beat did not start a line");

    a_idle_step_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !is_load && !r_active) |=> !r_out_valid)
        else $error("step while idle produced a pixel");

endmodule

`default_nettype wire

// ----- rtl/line_rasterizer.sv -----
// a step beat passes the setup register, then the command queue, then the pixel
// register before its pixel shows on the output
// throughput: one beat per cycle, loads and steps alike, while the output is ready;
// the walker runs one error update a cycle and the four-entry queue absorbs output stalls
// reset: synchronous, active low; line goes idle, screen size returns to 240 x 320
`default_nettype none

module line_rasterizer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [lr_pkg::CfgIdxBits-1:0] i_cfg_index,
    input  wire logic [lr_pkg::ScrBits-1:0]   i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_mode,
    input  wire logic [lr_pkg::FieldBits-1:0] i_x_start,
    input  wire logic [lr_pkg::FieldBits-1:0] i_y_start,
    input  wire logic [lr_pkg::FieldBits-1:0] i_x_end,
    input  wire logic [lr_pkg::FieldBits-1:0] i_y_end,
    input  wire logic [lr_pkg::ColorBits-1:0] i_pen_color,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [lr_pkg::FieldBits-1:0] o_pixel_x,
    output logic signed [lr_pkg::FieldBits-1:0] o_pixel_y,
    output logic [lr_pkg::ColorBits-1:0]      o_pixel_color,
    output logic                              o_on_screen,
    output logic                              o_last
);
    import lr_pkg::*;

    t_scr r_screen_width, r_screen_height;

    logic push, full, q_valid, pop;
    t_cmd push_cmd, q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= ScreenWidthReset;
            r_screen_height <= ScreenHeightReset;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lr_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_pen_color (i_pen_color),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    lr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    lr_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_on_screen     (o_on_screen),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire
